// ----- rtl/core/bdb_pkg.sv -----
// ----------------------------------------------------------------------------
// bdb_pkg: shared types and constants of the blink detector
// Eye-state and action codes, configuration register indexes, reset values
// and the control structs passed between the window and its cells.
// ----------------------------------------------------------------------------
`default_nettype none
package bdb_pkg;

	typedef enum logic [1:0] {
		EYE_CLOSED = 2'd0,
		EYE_OPEN   = 2'd1,
		EYE_UNDEF  = 2'd2,
		EYE_NONE   = 2'd3
	} eye_state_t;

	typedef enum logic {
		ACT_PROCESS = 1'b0,
		ACT_CLEAR   = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_BLINK_MIN   = 2'd1,
		REG_DBL_GAP     = 2'd2,
		REG_UNUSED      = 2'd3
	} cfg_reg_t;

	localparam logic [6:0]  WINDOW_SIZE_RST = 7'd5;
	localparam logic [6:0]  BLINK_MIN_RST   = 7'd2;
	localparam logic [15:0] DBL_GAP_RST     = 16'd15;
	localparam logic [31:0] LAST_BLINK_RST  = 32'hFFFF_FF9C;
	localparam logic [15:0] RUN_LIMIT       = 16'hFFFF;

	// request into the window: one defined classification or a clear
	typedef struct packed {
		logic clear;
		logic push;
		logic closed;
	} bdb_win_req_t;

	// broadcast from the window to every cell
	typedef struct packed {
		logic clear;
		logic push;
		logic drop;
	} bdb_cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/bdb_cell.sv -----
// ----------------------------------------------------------------------------
// bdb_cell: one entry of the sliding window
// Holds a valid bit and a closed bit; takes its left neighbor's entry on each
// push and drops itself when it is the tail and a drop is requested.
// ----------------------------------------------------------------------------
`default_nettype none
module bdb_cell
	import bdb_pkg::*;
#(
	parameter bit LAST_CELL = 1'b0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bdb_cell_ctl_t ctl,
	input  wire logic          in_v,
	input  wire logic          in_c,
	output logic               v_q,
	output logic               c_q,
	output logic               tail_closed
);

	logic tail;

	// tail after the shift: neighbor entry arrives here and nothing follows it
	assign tail        = in_v & (LAST_CELL | ~v_q);
	assign tail_closed = tail & in_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl.clear) begin
			v_q <= 1'b0;
		end else if (ctl.push) begin
			v_q <= in_v & ~(ctl.drop & tail);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			c_q <= in_c;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/bdb_window.sv -----
// ----------------------------------------------------------------------------
// bdb_window: sliding window of recent classifications
// A chain of cells, newest at cell 0, with fill and closed counters. Gives
// the closed count as it stands after the current push.
// ----------------------------------------------------------------------------
`default_nettype none
module bdb_window
	import bdb_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bdb_win_req_t                     req,
	input  wire logic [6:0]                       window_size,
	output logic [$clog2(WINDOW_MAX + 1) - 1 : 0] closed_after
);

	localparam int FW = $clog2(WINDOW_MAX + 1);
	localparam int CW = (FW > 7) ? FW : 7;
	localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_MAX);

	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         closed_q;
	logic [FW-1:0]         fill_push;
	logic                  full;
	logic                  drop;
	logic                  drop_full;
	logic                  drop_tail;
	logic [WINDOW_MAX-1:0] v_chain;
	logic [WINDOW_MAX-1:0] c_chain;
	logic [WINDOW_MAX-1:0] tail_closed;
	bdb_cell_ctl_t         ctl;

	assign full      = (fill_q == FILL_FULL);
	assign fill_push = full ? fill_q : fill_q + FW'(1);
	assign drop      = CW'(fill_push) > CW'(window_size);

	// entry falling off the end of a full chain, then the tail dropped by size
	assign drop_full = full & v_chain[WINDOW_MAX-1] & c_chain[WINDOW_MAX-1];
	assign drop_tail = drop & (|tail_closed);

	assign closed_after = closed_q + FW'(req.closed) - FW'(drop_full) - FW'(drop_tail);

	assign ctl.clear = req.clear;
	assign ctl.push  = req.push;
	assign ctl.drop  = drop;

	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		logic left_v;
		logic left_c;
		if (k == 0) begin : g_head
			assign left_v = 1'b1;
			assign left_c = req.closed;
		end else begin : g_body
			assign left_v = v_chain[k-1];
			assign left_c = c_chain[k-1];
		end
		bdb_cell #(
			.LAST_CELL(k == WINDOW_MAX - 1)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.in_v       (left_v),
			.in_c       (left_c),
			.v_q        (v_chain[k]),
			.c_q        (c_chain[k]),
			.tail_closed(tail_closed[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			closed_q <= '0;
		end else if (req.clear) begin
			fill_q   <= '0;
			closed_q <= '0;
		end else if (req.push) begin
			fill_q   <= fill_push - FW'(drop);
			closed_q <= closed_after;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/blink_double_blink_detector_unit.sv -----
// ----------------------------------------------------------------------------
// blink_double_blink_detector_unit: blink and double-blink event filter
// Turns per-frame eye classifications into blink and double-blink flags.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready, action, eye_state): one request per
//   frame; action clear restores the power-up state, config registers apart.
//   result channel (result_valid/result_ready, state_echo, blink_detected,
//   double_blink): exactly one result per request, in order.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; write only while idle. Change window_size after a clear.
// Latency: the result is valid the cycle after its request is taken.
// Throughput: one request per cycle while each result is taken; the whole update
//   of the window chain and the run/blink logic completes in that cycle.
// Reset: valid bits, counters and config registers return to defaults at once;
//   closed bits and result payload are not reset; no clearing pass is needed.
// Stall: a held result keeps its register; a new request is taken in the
//   same cycle that the pending result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module blink_double_blink_detector_unit
	import bdb_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        action,
	input  wire logic [1:0]  eye_state,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [1:0]       state_echo,
	output logic             blink_detected,
	output logic             double_blink
);

	localparam int FW = $clog2(WINDOW_MAX + 1);
	localparam int CW = (FW > 7) ? FW : 7;

	logic [6:0]    window_size_q;
	logic [6:0]    blink_min_q;
	logic [15:0]   dbl_gap_q;
	logic [15:0]   run_q;
	logic          prev_open_q;
	logic [31:0]   frame_q;
	logic [31:0]   last_blink_q;
	logic          result_valid_q;
	logic [1:0]    echo_q;
	logic          blink_q;
	logic          dbl_q;

	logic          accept;
	logic          is_clear;
	logic          defined;
	logic          push;
	logic          now_open;
	logic          blink;
	logic          dbl;
	logic [31:0]   distance;
	logic [FW-1:0] closed_after;
	bdb_win_req_t  win_req;

	assign cfg_ready  = 1'b1;
	assign item_ready = ~result_valid_q | result_ready;
	assign accept     = item_valid & item_ready;
	assign is_clear   = (action == ACT_CLEAR);
	assign defined    = (eye_state == EYE_CLOSED) || (eye_state == EYE_OPEN);
	assign push       = accept & ~is_clear & defined;

	assign win_req.clear  = accept & is_clear;
	assign win_req.push   = push;
	assign win_req.closed = (eye_state == EYE_CLOSED);

	bdb_window #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (win_req),
		.window_size (window_size_q),
		.closed_after(closed_after)
	);

	assign now_open = (eye_state == EYE_OPEN) && (CW'(closed_after) < CW'(blink_min_q));
	assign distance = frame_q - last_blink_q;
	assign blink    = now_open & ~prev_open_q & (run_q >= {9'd0, blink_min_q});
	assign dbl      = blink & (distance <= {16'd0, dbl_gap_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
			blink_min_q   <= BLINK_MIN_RST;
			dbl_gap_q     <= DBL_GAP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW_SIZE: window_size_q <= cfg_data[6:0];
				REG_BLINK_MIN:   blink_min_q   <= cfg_data[6:0];
				REG_DBL_GAP:     dbl_gap_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= '0;
			prev_open_q  <= 1'b1;
			frame_q      <= '0;
			last_blink_q <= LAST_BLINK_RST;
		end else if (accept) begin
			if (is_clear) begin
				run_q        <= '0;
				prev_open_q  <= 1'b1;
				frame_q      <= '0;
				last_blink_q <= LAST_BLINK_RST;
			end else begin
				if (defined) begin
					if (!now_open) begin
						if (run_q != RUN_LIMIT) begin
							run_q <= run_q + 16'd1;
						end
					end else begin
						run_q <= '0;
					end
					prev_open_q <= now_open;
					if (blink) begin
						// a double blink consumes the previous mark
						last_blink_q <= dbl ? LAST_BLINK_RST : frame_q;
					end
				end
				if (eye_state != EYE_NONE) begin
					frame_q <= frame_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_ready) begin
			result_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			echo_q  <= is_clear ? 2'd0 : eye_state;
			blink_q <= ~is_clear & defined & blink;
			dbl_q   <= ~is_clear & defined & dbl;
		end
	end

	assign result_valid   = result_valid_q;
	assign state_echo     = echo_q;
	assign blink_detected = blink_q;
	assign double_blink   = dbl_q;

endmodule
`default_nettype wire
